### sv/rspt_pkg.sv
// Package for the reference-counted shared segment table.
// Holds field widths, default parameters, status codes, controller states
// and the command and status bundles between controller and datapath.
package rspt_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_FRAME_BITS    = 20;

	localparam int SEG_ID_W = 32;
	localparam int COUNT_W  = 8;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	localparam logic CMD_OPEN  = 1'b0;
	localparam logic CMD_CLOSE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STS_OPENED       = 3'd0,
		STS_CREATED      = 3'd1,
		STS_CLOSED_USED  = 3'd2,
		STS_CLOSED_FREED = 3'd3,
		STS_NOT_FOUND    = 3'd4,
		STS_FULL         = 3'd5,
		STS_BAD_ID       = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_bad;
		logic scan_last;
		logic out_busy;
	} dp_status_t;

endpackage

### sv/rspt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the segment table storage.
module rspt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/rspt_ctrl.sv
// Controller state machine for the segment table: accept, scan, drain, commit.
// Depends on rspt_pkg for state encoding and the command/status bundles.
module rspt_ctrl import rspt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	output ctrl_cmd_t  cmd,
	input  dp_status_t stat
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// A zero id needs no lookup and goes straight to the result.
				if (stat.req_bad) begin
					state_d = S_COMMIT;
				end else if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!stat.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.accept    = s_axis_tvalid;
			end
			S_SCAN: begin
				cmd.scan_step = !stat.req_bad;
			end
			S_DRAIN: begin
			end
			S_COMMIT: begin
				cmd.commit = !stat.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/rspt_dp.sv
// Datapath of the segment table: request registers, table RAM, scan compare,
// fill count, update logic and the output register.
// Depends on rspt_pkg and rspt_ram.
module rspt_dp import rspt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int FRAME_BITS    = DEF_FRAME_BITS,
	parameter int IN_W          = 56,
	parameter int OUT_W         = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IN_W-1:0]     s_axis_tdata,
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_W-1:0]    m_axis_tdata,
	output logic [STATUS_W-1:0] m_axis_tuser,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          stat
);

	localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FW      = AW + 1;
	localparam int ENTRY_W = SEG_ID_W + FRAME_BITS + COUNT_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	// Request
	logic                  req_close_q;
	logic [SEG_ID_W-1:0]   req_id_q;
	logic [FRAME_BITS-1:0] req_frame_q;

	// Scan
	logic [AW-1:0]         addr_q;
	logic                  rd_valid_s1;
	logic [AW-1:0]         idx_s1;
	logic [ENTRY_W-1:0]    rdata;
	logic [SEG_ID_W-1:0]   rd_id;
	logic [FRAME_BITS-1:0] rd_frame;
	logic [COUNT_W-1:0]    rd_count;
	logic                  in_range;
	logic                  rd_live;

	logic                  hit_q;
	logic [AW-1:0]         hit_idx_q;
	logic [FRAME_BITS-1:0] hit_frame_q;
	logic [COUNT_W-1:0]    hit_count_q;
	logic                  free_q;
	logic [AW-1:0]         free_idx_q;
	logic [FW-1:0]         fill_q;

	// Update
	logic                  wr_need;
	logic                  fill_grow;
	logic [AW-1:0]         res_idx;
	logic [ENTRY_W-1:0]    wdata;
	status_t               res_status;
	logic [FRAME_BITS-1:0] res_frame;
	logic [COUNT_W-1:0]    res_count;
	logic [COUNT_W-1:0]    cnt_inc;
	logic [COUNT_W-1:0]    cnt_dec;
	logic [SLOT_W+AW-1:0]  slot_ext;

	// Output
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [FRAME_BITS-1:0] out_frame_q;
	logic [COUNT_W-1:0]    out_count_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_close_q <= s_axis_tuser;
			req_id_q    <= s_axis_tdata[SEG_ID_W-1:0];
			req_frame_q <= s_axis_tdata[SEG_ID_W +: FRAME_BITS];
		end
	end

	rspt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.commit && wr_need),
		.waddr(res_idx),
		.wdata(wdata),
		.re   (cmd.scan_step),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign rd_id    = rdata[SEG_ID_W-1:0];
	assign rd_frame = rdata[SEG_ID_W +: FRAME_BITS];
	assign rd_count = rdata[SEG_ID_W + FRAME_BITS +: COUNT_W];

	// Entries at or above the fill count were never written and read as free.
	assign in_range = {1'b0, idx_s1} < fill_q;
	assign rd_live  = in_range && (rd_count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_step;
			if (cmd.accept) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (rd_valid_s1) begin
				if (rd_live && (rd_id == req_id_q) && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!rd_live && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit && fill_grow) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= '0;
		end else if (cmd.scan_step) begin
			addr_q <= addr_q + AW'(1);
		end
		idx_s1 <= addr_q;
		if (rd_valid_s1 && rd_live && (rd_id == req_id_q) && !hit_q) begin
			hit_idx_q   <= idx_s1;
			hit_frame_q <= rd_frame;
			hit_count_q <= rd_count;
		end
		if (rd_valid_s1 && !rd_live && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign cnt_inc = (hit_count_q == COUNT_MAX) ? hit_count_q : hit_count_q + COUNT_W'(1);
	assign cnt_dec = hit_count_q - COUNT_W'(1);

	always_comb begin
		wr_need    = 1'b0;
		fill_grow  = 1'b0;
		res_idx    = '0;
		res_status = STS_BAD_ID;
		res_frame  = '0;
		res_count  = '0;
		wdata      = '0;
		if (req_id_q == '0) begin
			res_status = STS_BAD_ID;
		end else if (req_close_q == CMD_OPEN) begin
			if (hit_q) begin
				wr_need    = 1'b1;
				res_idx    = hit_idx_q;
				res_status = STS_OPENED;
				res_frame  = hit_frame_q;
				res_count  = cnt_inc;
				wdata      = {cnt_inc, hit_frame_q, req_id_q};
			end else if (free_q) begin
				wr_need    = 1'b1;
				fill_grow  = ({1'b0, free_idx_q} == fill_q);
				res_idx    = free_idx_q;
				res_status = STS_CREATED;
				res_frame  = req_frame_q;
				res_count  = COUNT_W'(1);
				wdata      = {COUNT_W'(1), req_frame_q, req_id_q};
			end else begin
				res_status = STS_FULL;
			end
		end else begin
			if (!hit_q) begin
				res_status = STS_NOT_FOUND;
			end else if (cnt_dec == '0) begin
				// The freed entry goes back to id zero, frame zero.
				wr_need    = 1'b1;
				res_idx    = hit_idx_q;
				res_status = STS_CLOSED_FREED;
			end else begin
				wr_need    = 1'b1;
				res_idx    = hit_idx_q;
				res_status = STS_CLOSED_USED;
				res_frame  = hit_frame_q;
				res_count  = cnt_dec;
				wdata      = {cnt_dec, hit_frame_q, req_id_q};
			end
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, res_idx};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_slot_q   <= slot_ext[SLOT_W-1:0];
			out_frame_q  <= res_frame;
			out_count_q  <= res_count;
		end
	end

	assign m_axis_tvalid  = out_valid_q;
	assign m_axis_tuser   = out_status_q;
	assign m_axis_tdata   = OUT_W'({out_count_q, out_frame_q, out_slot_q});

	assign stat.req_bad   = (req_id_q == '0);
	assign stat.scan_last = (addr_q == LAST_IDX);
	assign stat.out_busy  = out_valid_q && !m_axis_tready;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(TABLE_ENTRIES))
		else $error("fill count exceeds table size");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_axis_tvalid)
		else $error("committed result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !m_axis_tready))
		else $error("result overwritten while stalled");

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(cmd.scan_step))
		else $error("compare without a table read");

endmodule

### sv/refcounted_shared_page_table.sv
// Reference-counted shared segment table, top level.
// One request word enters on the s_axis channel: tuser carries the command
// (open or close), tdata carries the segment id and the new frame number.
// One result word leaves on the m_axis channel for every request: tuser
// carries the status, tdata carries slot, frame and reference count.
// A request walks the table RAM between acceptance and the result register:
// the controller reads one entry per cycle through its single read port,
// then passes a drain state for the last read and a commit state for the
// update write. A request with id zero skips the walk and goes straight
// to the commit state. One request is in flight at a time, and the next
// one can be accepted in the cycle after the result is registered.
// The result sits in an output register; the next request is accepted
// while it waits, and its update holds off until the result is taken.
// Reset empties the table at once through a fill count that marks entries
// never written as free; no clearing pass is needed.
// Depends on rspt_pkg, rspt_ctrl, rspt_dp and rspt_ram.
module refcounted_shared_page_table import rspt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int FRAME_BITS    = DEF_FRAME_BITS,
	parameter int IN_W          = ((SEG_ID_W + FRAME_BITS + 7) / 8) * 8,
	parameter int OUT_W         = ((SLOT_W + FRAME_BITS + COUNT_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_W-1:0]     s_axis_tdata,  // seg_id, new_frame
	input  logic                s_axis_tuser,  // cmd
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_W-1:0]    m_axis_tdata,  // slot, frame, ref_count
	output logic [STATUS_W-1:0] m_axis_tuser   // status
);

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	rspt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.cmd          (cmd),
		.stat         (stat)
	);

	rspt_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRAME_BITS   (FRAME_BITS),
		.IN_W         (IN_W),
		.OUT_W        (OUT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

### test/tb_refcounted_shared_page_table.sv
// Testbench for the reference-counted shared segment table.
// Drives open and close requests, predicts each result and checks every result word.
// Depends on rspt_pkg and refcounted_shared_page_table.
module tb_refcounted_shared_page_table;
	import rspt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W      = 56;
	localparam int OUT_W     = 40;
	localparam int ENTRIES   = 64;
	localparam int RUN_LIMIT = 400000;

	typedef struct packed {
		logic        cmd;
		logic [31:0] id;
		logic [19:0] frame;
		logic        drain;
	} seg_req_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  slot;
		logic [19:0] frame;
		logic [7:0]  count;
	} seg_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;   // seg_id, new_frame
	logic             s_axis_tuser = CMD_OPEN;  // cmd
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // slot, frame, ref_count
	logic [2:0]       m_axis_tuser;        // status

	// Shadow copy of the segment table.
	logic [31:0] seg_ids    [ENTRIES];
	logic [19:0] seg_frames [ENTRIES];
	logic [7:0]  seg_refs   [ENTRIES];

	seg_req_t    queued_requests [$];
	seg_result_t due_outcomes    [$];
	seg_req_t    in_flight;
	seg_result_t want;
	int          send_gap = 0;
	int          stall_left = 0;
	int          mismatches = 0;
	int          cycle_count = 0;

	refcounted_shared_page_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idling alternates with quiet windows and stops near the end of the run.
	function automatic bit idling_on();
		return cycle_count[8] && queued_requests.size() > 40;
	endfunction

	function automatic logic [31:0] nonzero_id();
		logic [31:0] id;
		do
			id = $urandom;
		while (id == 32'h0);
		return id;
	endfunction

	// Applies one request to the shadow table and returns the result it must produce.
	function automatic seg_result_t table_outcome(seg_req_t req);
		seg_result_t res;
		int hit;
		int free_slot;
		res = '0;
		hit = -1;
		free_slot = -1;
		if (req.id == 32'h0) begin
			res.status = STS_BAD_ID;
			return res;
		end
		for (int k = 0; k < ENTRIES; k++) begin
			if (hit < 0 && seg_refs[k] != 8'h0 && seg_ids[k] == req.id)
				hit = k;
			if (free_slot < 0 && seg_refs[k] == 8'h0)
				free_slot = k;
		end
		if (req.cmd == CMD_OPEN) begin
			if (hit >= 0) begin
				if (seg_refs[hit] != COUNT_MAX)
					seg_refs[hit]++;
				res.status = STS_OPENED;
				res.slot   = hit[5:0];
				res.frame  = seg_frames[hit];
				res.count  = seg_refs[hit];
			end else if (free_slot < 0) begin
				res.status = STS_FULL;
			end else begin
				seg_ids[free_slot]    = req.id;
				seg_frames[free_slot] = req.frame;
				seg_refs[free_slot]   = 8'd1;
				res.status = STS_CREATED;
				res.slot   = free_slot[5:0];
				res.frame  = req.frame;
				res.count  = 8'd1;
			end
		end else if (hit < 0) begin
			res.status = STS_NOT_FOUND;
		end else begin
			seg_refs[hit]--;
			res.slot = hit[5:0];
			if (seg_refs[hit] == 8'h0) begin
				seg_ids[hit]    = 32'h0;
				seg_frames[hit] = 20'h0;
				res.status = STS_CLOSED_FREED;
			end else begin
				res.status = STS_CLOSED_USED;
				res.frame  = seg_frames[hit];
				res.count  = seg_refs[hit];
			end
		end
		return res;
	endfunction

	task automatic add_request(logic cmd, logic [31:0] id, logic [19:0] frame, logic drain);
		seg_req_t req;
		req.cmd   = cmd;
		req.id    = id;
		req.frame = frame;
		req.drain = drain;
		queued_requests.push_back(req);
	endtask

	task automatic flag_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (actual !== expected) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, expected, actual);
			mismatches++;
		end
	endtask

	// Request driver; the expectation is formed when the word is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= CMD_OPEN;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				due_outcomes.push_back(table_outcome(in_flight));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (queued_requests.size() != 0 &&
				    !(queued_requests[0].drain && due_outcomes.size() != 0)) begin
					in_flight = queued_requests.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'h0, in_flight.frame, in_flight.id};
					s_axis_tuser  <= in_flight.cmd;
					if (idling_on() && $urandom_range(0, 3) == 0)
						send_gap <= $urandom_range(1, 3);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random backpressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_outcomes.size() == 0) begin
					$display("%0t: unexpected word, expected none actual status %0h data %0h",
					    $time, m_axis_tuser, m_axis_tdata);
					mismatches++;
				end else begin
					want = due_outcomes.pop_front();
					flag_field("status", 32'(want.status), 32'(m_axis_tuser));
					flag_field("slot", 32'(want.slot), 32'(m_axis_tdata[5:0]));
					flag_field("frame", 32'(want.frame), 32'(m_axis_tdata[25:6]));
					flag_field("ref_count", 32'(want.count), 32'(m_axis_tdata[33:26]));
				end
			end
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else if (idling_on() && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left    <= $urandom_range(0, 2);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [31:0] pool [12];
		logic [31:0] fill_ids [$];
		logic [31:0] sat_id;
		logic [31:0] pick;
		int roll;
		for (int k = 0; k < ENTRIES; k++) begin
			seg_ids[k]    = 32'h0;
			seg_frames[k] = 20'h0;
			seg_refs[k]   = 8'h0;
		end

		// Directed: bad ids, create, hit, reuse of the lowest free entry, unknown close.
		add_request(CMD_OPEN,  32'h0,        20'hFFFFF, 1'b0);
		add_request(CMD_CLOSE, 32'h0,        20'h00000, 1'b0);
		add_request(CMD_CLOSE, 32'hFFFFFFFF, 20'hFFFFF, 1'b0);
		add_request(CMD_OPEN,  32'hFFFFFFFF, 20'hFFFFF, 1'b0);
		add_request(CMD_OPEN,  32'hFFFFFFFF, 20'h00000, 1'b0);
		add_request(CMD_OPEN,  32'h00000001, 20'h00000, 1'b0);
		add_request(CMD_OPEN,  32'h80000000, 20'h80000, 1'b0);
		add_request(CMD_CLOSE, 32'h00000001, 20'hFFFFF, 1'b0);
		add_request(CMD_OPEN,  32'h5A5A5A5A, 20'h5A5A5, 1'b1);
		add_request(CMD_CLOSE, 32'hFFFFFFFF, 20'h00000, 1'b0);
		add_request(CMD_CLOSE, 32'hFFFFFFFF, 20'h00000, 1'b0);
		add_request(CMD_CLOSE, 32'hFFFFFFFF, 20'h00000, 1'b0);
		add_request(CMD_OPEN,  32'h80000000, 20'h12345, 1'b0);
		add_request(CMD_CLOSE, 32'h0,        20'hFFFFF, 1'b0);

		// Fill the table past its capacity, then free some entries and refill them.
		for (int i = 0; i < 66; i++) begin
			pick = nonzero_id();
			fill_ids.push_back(pick);
			add_request(CMD_OPEN, pick, 20'($urandom), 1'b0);
		end
		add_request(CMD_OPEN, 32'h80000000, 20'($urandom), 1'b0);
		for (int i = 0; i < 30; i++) begin
			if ($urandom_range(0, 2) == 0)
				add_request(CMD_OPEN, nonzero_id(), 20'($urandom), 1'b0);
			else
				add_request(CMD_CLOSE, fill_ids[$urandom_range(0, 65)], 20'($urandom), 1'b0);
		end

		// One segment opened until its count saturates.
		sat_id = nonzero_id();
		add_request(CMD_CLOSE, fill_ids[0], 20'($urandom), 1'b1);
		for (int i = 0; i < 258; i++)
			add_request(CMD_OPEN, sat_id, 20'($urandom), 1'b0);
		for (int i = 0; i < 3; i++)
			add_request(CMD_CLOSE, sat_id, 20'($urandom), 1'b0);

		// Mixed traffic over a small set of ids, with some noise.
		foreach (pool[i])
			pool[i] = nonzero_id();
		pool[0] = 32'hFFFFFFFF;
		for (int i = 0; i < 180; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				pick = 32'h0;
			else if (roll < 12)
				pick = nonzero_id();
			else
				pick = pool[$urandom_range(0, 11)];
			add_request(($urandom_range(0, 99) < 55) ? CMD_OPEN : CMD_CLOSE, pick,
			    20'($urandom), i == 90);
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (queued_requests.size() != 0 || s_axis_tvalid || due_outcomes.size() != 0);
		repeat (100) @(negedge clk);
		if (mismatches == 0 && due_outcomes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
